FILE: rtl/jcwt_pkg.sv
// Package for the job completion window tracker.
// Holds field widths, status/mode/command codes and the controller-datapath structs.
// No dependencies.
package jcwt_pkg;

	localparam int unsigned JCWT_WINDOW = 64;
	localparam int unsigned ID_W        = 24;
	localparam int unsigned BASE_W      = 25;

	localparam logic CMD_ACQUIRE  = 1'b0;
	localparam logic CMD_REGISTER = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_BAD_ID    = 2'd3;

	localparam logic [1:0] MODE_NORMAL    = 2'd0;
	localparam logic [1:0] MODE_EXCEPTION = 2'd1;
	localparam logic [1:0] MODE_CANCEL    = 2'd2;

	localparam logic [ID_W-1:0] EXC_CNT_MAX = '1;

	typedef struct packed {
		logic load_in;
		logic exec;
		logic scan;
		logic load_out;
	} jcwt_cmd_t;

	typedef struct packed {
		logic scan_req;
	} jcwt_stat_t;

endpackage

FILE: rtl/jcwt_if.sv
// Channel interfaces for the job completion window tracker: request, result, config.
// Depends on jcwt_pkg.
interface jcwt_in_if import jcwt_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            command;
	logic [ID_W-1:0] job_id;
	logic            exceptional;
	logic            cancel_requested;

	modport source (output valid, command, job_id, exceptional, cancel_requested,
		input ready);
	modport sink (input valid, command, job_id, exceptional, cancel_requested,
		output ready);
endinterface

interface jcwt_out_if import jcwt_pkg::*; #(
	parameter int unsigned CNT_W = $clog2(JCWT_WINDOW + 1)
) ();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [ID_W-1:0]   granted_id;
	logic              exhausted;
	logic [BASE_W-1:0] lowest_unfinished;
	logic [CNT_W-1:0]  pending_count;
	logic [ID_W-1:0]   exception_count;
	logic [ID_W-1:0]   first_exception_id;
	logic [1:0]        run_mode;

	modport source (output valid, status, granted_id, exhausted, lowest_unfinished,
		pending_count, exception_count, first_exception_id, run_mode, input ready);
	modport sink (input valid, status, granted_id, exhausted, lowest_unfinished,
		pending_count, exception_count, first_exception_id, run_mode, output ready);
endinterface

interface jcwt_cfg_if import jcwt_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: rtl/job_completion_window_tracker_core.sv
// Job completion window tracker: request, result and config channels.
// Result payload sits in a register in the datapath. Each request is captured, then
// executed, then goes through the base scan when the window base completes, and is
// then loaded into the result register.
// A new request is taken as soon as the previous one is loaded into the result register,
// even while that result still waits at the output. A request that finds the result
// register still full waits in the controller until the receiver takes the old result.
// The base scan is a priority search over the pending bitmap.
// Config: write job_count on the cfg channel while no request is in flight; it is always
// ready.
// Reset (arst_n low) clears the bitmap, sets next id and window base to 1, clears the
// exception state, run mode and job_count, and empties the result register.
// Depends on jcwt_pkg, jcwt_if, jcwt_ctrl and jcwt_dp.
module job_completion_window_tracker_core import jcwt_pkg::*; #(
	parameter int unsigned WINDOW = JCWT_WINDOW
) (
	input logic         clk,
	input logic         arst_n,
	jcwt_in_if.sink     job_in,
	jcwt_out_if.source  job_out,
	jcwt_cfg_if.sink    cfg
);

	localparam int unsigned CNT_W = $clog2(WINDOW + 1);

	jcwt_cmd_t  cmd;
	jcwt_stat_t stat;

	assign cfg.ready = 1'b1;

	jcwt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (job_in.valid),
		.in_ready  (job_in.ready),
		.out_valid (job_out.valid),
		.out_ready (job_out.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	jcwt_dp #(
		.WINDOW (WINDOW),
		.CNT_W  (CNT_W)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg.valid),
		.cfg_data           (cfg.data),
		.in_command         (job_in.command),
		.in_job_id          (job_in.job_id),
		.in_exceptional     (job_in.exceptional),
		.in_cancel          (job_in.cancel_requested),
		.cmd                (cmd),
		.stat               (stat),
		.status             (job_out.status),
		.granted_id         (job_out.granted_id),
		.exhausted          (job_out.exhausted),
		.lowest_unfinished  (job_out.lowest_unfinished),
		.pending_count      (job_out.pending_count),
		.exception_count    (job_out.exception_count),
		.first_exception_id (job_out.first_exception_id),
		.run_mode           (job_out.run_mode)
	);

endmodule

FILE: rtl/jcwt_ctrl.sv
// Controller state machine: sequences capture, execute, base scan and result load.
// Depends on jcwt_pkg; drives jcwt_dp through jcwt_cmd_t.
module jcwt_ctrl import jcwt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  jcwt_stat_t stat,
	output jcwt_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.scan_req ? S_SCAN : S_DONE;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				// hold the result until the output register frees up
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/jcwt_dp.sv
// Datapath: id counters, pending bitmap, run mode, base scan and result register.
// Depends on jcwt_pkg; commanded by jcwt_ctrl.
module jcwt_dp import jcwt_pkg::*; #(
	parameter int unsigned WINDOW = JCWT_WINDOW,
	parameter int unsigned CNT_W  = $clog2(WINDOW + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ID_W-1:0]   cfg_data,
	input  logic              in_command,
	input  logic [ID_W-1:0]   in_job_id,
	input  logic              in_exceptional,
	input  logic              in_cancel,
	input  jcwt_cmd_t         cmd,
	output jcwt_stat_t        stat,
	output logic [1:0]        status,
	output logic [ID_W-1:0]   granted_id,
	output logic              exhausted,
	output logic [BASE_W-1:0] lowest_unfinished,
	output logic [CNT_W-1:0]  pending_count,
	output logic [ID_W-1:0]   exception_count,
	output logic [ID_W-1:0]   first_exception_id,
	output logic [1:0]        run_mode
);

	localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [SLOT_W:0]     WIN_S     = (SLOT_W + 1)'(WINDOW);
	localparam logic [SLOT_W-1:0]   SLOT_LAST = SLOT_W'(WINDOW - 1);
	localparam logic [BASE_W-1:0]   WIN_B     = BASE_W'(WINDOW);

	// architectural state
	logic [ID_W-1:0]   job_count_q;
	logic [BASE_W-1:0] next_id_q;
	logic [BASE_W-1:0] base_q;
	logic [SLOT_W-1:0] next_slot_q;
	logic [SLOT_W-1:0] base_slot_q;
	logic [WINDOW-1:0] pend_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [1:0]        mode_q;
	logic [ID_W-1:0]   exc_cnt_q;
	logic [ID_W-1:0]   first_bad_q;

	// captured request and per-item result
	logic              cmd_q;
	logic [ID_W-1:0]   id_q;
	logic              bad_q;
	logic              cancel_q;
	logic [1:0]        status_q;
	logic [ID_W-1:0]   granted_q;

	// result register
	logic [1:0]        out_status_q;
	logic [ID_W-1:0]   out_granted_q;
	logic              out_exh_q;
	logic [BASE_W-1:0] out_base_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic [ID_W-1:0]   out_exc_q;
	logic [ID_W-1:0]   out_first_q;
	logic [1:0]        out_mode_q;

	logic              exhausted_c;
	logic              full_c;
	logic [BASE_W-1:0] span_c;
	logic [BASE_W-1:0] id_ext;
	logic [BASE_W-1:0] off_c;
	logic              in_win;
	logic [SLOT_W:0]   slot_sum;
	logic [SLOT_W:0]   slot_wrap;
	logic [SLOT_W-1:0] reg_slot;
	logic              hit;
	logic              acq_ok;
	logic              reg_ok;
	logic [1:0]        status_c;
	logic [SLOT_W-1:0] next_slot_inc;

	logic [WINDOW-1:0] hi_mask;
	logic [SLOT_W-1:0] first_hi;
	logic [SLOT_W-1:0] first_all;
	logic              any_hi;
	logic              any_pend;
	logic [SLOT_W-1:0] found;
	logic [SLOT_W:0]   base_gap;

	// request decode
	assign exhausted_c = (mode_q != MODE_NORMAL) || (next_id_q > {1'b0, job_count_q});
	assign span_c      = next_id_q - base_q;
	assign full_c      = (span_c >= WIN_B);
	assign id_ext      = {1'b0, id_q};
	assign in_win      = (id_ext >= base_q) && (id_ext < next_id_q);
	assign off_c       = id_ext - base_q;
	assign slot_sum    = {1'b0, base_slot_q} + {1'b0, off_c[SLOT_W-1:0]};
	assign slot_wrap   = (slot_sum >= WIN_S) ? (slot_sum - WIN_S) : slot_sum;
	assign reg_slot    = slot_wrap[SLOT_W-1:0];
	assign hit         = in_win && pend_q[reg_slot];
	assign acq_ok      = (cmd_q == CMD_ACQUIRE) && !exhausted_c && !full_c;
	assign reg_ok      = (cmd_q == CMD_REGISTER) && hit;
	assign next_slot_inc = (next_slot_q == SLOT_LAST) ? '0 : next_slot_q + 1'b1;

	assign stat.scan_req = reg_ok && (id_ext == base_q);

	always_comb begin
		if (cmd_q == CMD_ACQUIRE) begin
			if (exhausted_c) begin
				status_c = ST_EXHAUSTED;
			end else if (full_c) begin
				status_c = ST_FULL;
			end else begin
				status_c = ST_OK;
			end
		end else begin
			status_c = hit ? ST_OK : ST_BAD_ID;
		end
	end

	// base scan: first pending slot at or after the base slot, wrapping round
	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			hi_mask[i] = pend_q[i] && (SLOT_W'(i) >= base_slot_q);
		end
	end

	always_comb begin
		first_hi  = '0;
		first_all = '0;
		for (int i = WINDOW - 1; i >= 0; i--) begin
			if (hi_mask[i]) begin
				first_hi = SLOT_W'(i);
			end
			if (pend_q[i]) begin
				first_all = SLOT_W'(i);
			end
		end
	end

	assign any_hi   = |hi_mask;
	assign any_pend = |pend_q;
	assign found    = any_hi ? first_hi : first_all;
	assign base_gap = (found >= base_slot_q) ? ({1'b0, found} - {1'b0, base_slot_q})
		: ({1'b0, found} + WIN_S - {1'b0, base_slot_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_count_q <= '0;
			next_id_q   <= BASE_W'(1);
			base_q      <= BASE_W'(1);
			next_slot_q <= SLOT_W'(1 % WINDOW);
			base_slot_q <= SLOT_W'(1 % WINDOW);
			pend_q      <= '0;
			cnt_q       <= '0;
			mode_q      <= MODE_NORMAL;
			exc_cnt_q   <= '0;
			first_bad_q <= '0;
		end else begin
			if (cfg_we) begin
				job_count_q <= cfg_data;
			end
			if (cmd.exec && acq_ok) begin
				pend_q[next_slot_q] <= 1'b1;
				cnt_q               <= cnt_q + 1'b1;
				next_id_q           <= next_id_q + 1'b1;
				next_slot_q         <= next_slot_inc;
			end
			if (cmd.exec && reg_ok) begin
				pend_q[reg_slot] <= 1'b0;
				cnt_q            <= cnt_q - 1'b1;
				if (mode_q == MODE_NORMAL) begin
					if (bad_q) begin
						exc_cnt_q   <= ID_W'(1);
						first_bad_q <= id_q;
						mode_q      <= MODE_EXCEPTION;
					end else if (cancel_q) begin
						mode_q <= MODE_CANCEL;
					end
				end else if (mode_q == MODE_EXCEPTION) begin
					if (bad_q && (exc_cnt_q != EXC_CNT_MAX)) begin
						exc_cnt_q <= exc_cnt_q + 1'b1;
					end
				end
			end
			if (cmd.scan) begin
				// advance past the finished run to the next pending id, or to next_id
				if (any_pend) begin
					base_q      <= base_q + BASE_W'(base_gap);
					base_slot_q <= found;
				end else begin
					base_q      <= next_id_q;
					base_slot_q <= next_slot_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q    <= in_command;
			id_q     <= in_job_id;
			bad_q    <= in_exceptional;
			cancel_q <= in_cancel;
		end
		if (cmd.exec) begin
			status_q  <= status_c;
			granted_q <= acq_ok ? next_id_q[ID_W-1:0] : '0;
		end
		if (cmd.load_out) begin
			out_status_q  <= status_q;
			out_granted_q <= granted_q;
			out_exh_q     <= exhausted_c;
			out_base_q    <= base_q;
			out_cnt_q     <= cnt_q;
			out_exc_q     <= exc_cnt_q;
			out_first_q   <= first_bad_q;
			out_mode_q    <= mode_q;
		end
	end

	assign status             = out_status_q;
	assign granted_id         = out_granted_q;
	assign exhausted          = out_exh_q;
	assign lowest_unfinished  = out_base_q;
	assign pending_count      = out_cnt_q;
	assign exception_count    = out_exc_q;
	assign first_exception_id = out_first_q;
	assign run_mode           = out_mode_q;

`ifndef SYNTH
	a_count_matches_bitmap: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cnt_q) == 32'($countones(pend_q))))
		else $error("pending count differs from bitmap population");

	a_base_not_past_next: assert property (@(posedge clk) disable iff (!arst_n)
		(base_q <= next_id_q))
		else $error("window base beyond next id");

	a_span_within_window: assert property (@(posedge clk) disable iff (!arst_n)
		(span_c <= WIN_B))
		else $error("window span exceeds window size");

	a_scan_only_after_base_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> $past(cmd.exec && reg_ok))
		else $error("base scan without a completed base id");
`endif

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the job completion window tracker core.
// Drives the request and config channels and scores every result against a predictor.
// Depends on jcwt_pkg, the jcwt_if channel interfaces and the core itself.
`timescale 1ns / 100ps

module tb_top;
	import jcwt_pkg::*;

	localparam logic [ID_W-1:0] ID_MAX = '1;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		logic [1:0]        status;
		logic [ID_W-1:0]   granted_id;
		logic              exhausted;
		logic [BASE_W-1:0] lowest_unfinished;
		logic [6:0]        pending_count;
		logic [ID_W-1:0]   exception_count;
		logic [ID_W-1:0]   first_exception_id;
		logic [1:0]        run_mode;
	} job_result_t;

	logic clk;
	logic arst_n;

	jcwt_in_if  job_in_ch ();
	jcwt_out_if job_out_ch ();
	jcwt_cfg_if cfg_ch ();

	job_completion_window_tracker_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.job_in  (job_in_ch),
		.job_out (job_out_ch),
		.cfg     (cfg_ch)
	);

	// Predicted tracker state, at its reset values
	logic [BASE_W-1:0]      exp_next_id       = BASE_W'(1);
	logic [BASE_W-1:0]      exp_base          = BASE_W'(1);
	logic [JCWT_WINDOW-1:0] exp_pending_map   = '0;
	int                     exp_pending_total = 0;
	logic [1:0]             exp_mode          = MODE_NORMAL;
	logic [ID_W-1:0]        exp_exc_count     = '0;
	logic [ID_W-1:0]        exp_first_bad     = '0;
	logic [ID_W-1:0]        exp_job_count     = '0;

	job_result_t outcome_queue[$];

	int burst_left   = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int error_count  = 0;
	int idle_cycles  = 0;
	int ready_run    = 0;
	int ready_stall  = 0;
	int status_tally[4] = '{0, 0, 0, 0};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic source_dry();
		return exp_mode != MODE_NORMAL || exp_next_id > {1'b0, exp_job_count};
	endfunction

	function automatic logic is_pending(input logic [ID_W-1:0] id);
		return {1'b0, id} >= exp_base && {1'b0, id} < exp_next_id
			&& exp_pending_map[id % JCWT_WINDOW];
	endfunction

	function automatic job_result_t predict_job_outcome(input logic cmd,
			input logic [ID_W-1:0] id, input logic exc, input logic cancel);
		job_result_t r;
		r.status     = ST_OK;
		r.granted_id = '0;
		if (cmd == CMD_ACQUIRE) begin
			if (source_dry()) begin
				r.status = ST_EXHAUSTED;
			end else if (exp_next_id - exp_base >= JCWT_WINDOW) begin
				r.status = ST_FULL;
			end else begin
				exp_pending_map[exp_next_id % JCWT_WINDOW] = 1'b1;
				exp_pending_total++;
				r.granted_id = exp_next_id[ID_W-1:0];
				exp_next_id++;
			end
		end else if (!is_pending(id)) begin
			r.status = ST_BAD_ID;
		end else begin
			if (exp_mode == MODE_NORMAL) begin
				if (exc) begin
					exp_exc_count = ID_W'(1);
					exp_first_bad = id;
					exp_mode      = MODE_EXCEPTION;
				end else if (cancel) begin
					exp_mode = MODE_CANCEL;
				end
			end else if (exp_mode == MODE_EXCEPTION) begin
				if (exc && exp_exc_count != ID_MAX)
					exp_exc_count++;
			end
			exp_pending_map[id % JCWT_WINDOW] = 1'b0;
			exp_pending_total--;
			// Skip the base past the run of finished ids that follows
			if ({1'b0, id} == exp_base) begin
				while (exp_base < exp_next_id && !exp_pending_map[exp_base % JCWT_WINDOW])
					exp_base++;
			end
		end
		r.exhausted          = source_dry();
		r.lowest_unfinished  = exp_base;
		r.pending_count      = 7'(exp_pending_total);
		r.exception_count    = exp_exc_count;
		r.first_exception_id = exp_first_bad;
		r.run_mode           = exp_mode;
		return r;
	endfunction

	function automatic logic [ID_W-1:0] pick_pending_id();
		logic [BASE_W-1:0] cand;
		int span;
		int t;
		span = int'(exp_next_id - exp_base);
		if ($urandom_range(0, 3) != 0) begin
			for (t = 0; t < 4; t++) begin
				cand = exp_base + BASE_W'($urandom_range(0, span - 1));
				if (exp_pending_map[cand % JCWT_WINDOW])
					return cand[ID_W-1:0];
			end
		end
		return exp_base[ID_W-1:0];
	endfunction

	// Ids mostly off the pending set: far away, below the base, not yet granted,
	// or already cleared inside the window
	function automatic logic [ID_W-1:0] pick_stray_id();
		logic [ID_W-1:0] id;
		case ($urandom_range(0, 3))
			0: id = ID_W'($urandom_range(1, ID_MAX));
			1: id = (exp_base > 1) ? exp_base[ID_W-1:0] - 1'b1 : ID_W'($urandom_range(1, ID_MAX));
			2: id = exp_next_id[ID_W-1:0] + ID_W'($urandom_range(0, 3));
			default: id = exp_base[ID_W-1:0] + ID_W'($urandom_range(0, 70));
		endcase
		if (id == '0)
			id = 1;
		return id;
	endfunction

	task automatic send_job(input logic cmd, input logic [ID_W-1:0] id,
			input logic exc, input logic cancel);
		int gap;
		job_result_t predicted;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 16);
			if (gap > 0) begin
				@(negedge clk);
				job_in_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		job_in_ch.valid            <= 1'b1;
		job_in_ch.command          <= cmd;
		job_in_ch.job_id           <= id;
		job_in_ch.exceptional      <= exc;
		job_in_ch.cancel_requested <= cancel;
		do @(posedge clk); while (!job_in_ch.ready);
		predicted = predict_job_outcome(cmd, id, exc, cancel);
		outcome_queue = {outcome_queue, predicted};
		items_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		job_in_ch.valid <= 1'b0;
		while (outcome_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_job_count(input logic [ID_W-1:0] value);
		wait_idle();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		exp_job_count = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic test_empty_source();
		write_job_count('0);
		send_job(CMD_ACQUIRE, 24'd1, 1'b0, 1'b0);
		send_job(CMD_REGISTER, 24'd1, 1'b1, 1'b1);
		send_job(CMD_REGISTER, ID_MAX, 1'b0, 1'b0);
		send_job(CMD_ACQUIRE, ID_MAX, 1'b1, 1'b1);
	endtask

	task automatic test_small_source();
		write_job_count(24'd3);
		repeat (3) send_job(CMD_ACQUIRE, 24'd1, 1'b0, 1'b0);
		send_job(CMD_ACQUIRE, 24'd1, 1'b0, 1'b0);
		// Out-of-order completion holds the base, a repeat is refused
		send_job(CMD_REGISTER, 24'd2, 1'b0, 1'b0);
		send_job(CMD_REGISTER, 24'd2, 1'b0, 1'b0);
		send_job(CMD_REGISTER, 24'd5, 1'b0, 1'b0);
		send_job(CMD_REGISTER, 24'd1, 1'b0, 1'b0);
		send_job(CMD_REGISTER, 24'd3, 1'b0, 1'b0);
		send_job(CMD_REGISTER, 24'd1, 1'b0, 1'b0);
		send_job(CMD_ACQUIRE, 24'd1, 1'b0, 1'b0);
		// A larger count lifts the exhaustion
		write_job_count(24'd6);
		send_job(CMD_ACQUIRE, 24'd1, 1'b0, 1'b0);
		send_job(CMD_REGISTER, 24'd4, 1'b0, 1'b0);
	endtask

	// Alternate acquire-heavy, completion-heavy and mixed stretches so that
	// the window fills, drains and wraps
	task automatic random_traffic(input int n_items);
		int left_in_block;
		int acq_pct;
		int roll;
		int i;
		logic cmd;
		logic [ID_W-1:0] id;
		logic exc;
		logic cancel;
		left_in_block = 0;
		acq_pct = 50;
		for (i = 0; i < n_items; i++) begin
			if (left_in_block == 0) begin
				left_in_block = $urandom_range(60, 120);
				case ($urandom_range(0, 2))
					0: acq_pct = 90;
					1: acq_pct = 10;
					default: acq_pct = 50;
				endcase
			end
			left_in_block--;
			roll   = $urandom_range(0, 99);
			id     = ID_W'($urandom_range(1, ID_MAX));
			exc    = 1'($urandom_range(0, 1));
			cancel = 1'($urandom_range(0, 1));
			if (roll < 8) begin
				cmd = CMD_REGISTER;
				id  = pick_stray_id();
				// Keep the run in normal mode
				if (is_pending(id)) begin
					exc    = 1'b0;
					cancel = 1'b0;
				end
			end else if ($urandom_range(0, 99) < acq_pct || exp_pending_total == 0) begin
				cmd = CMD_ACQUIRE;
			end else begin
				cmd    = CMD_REGISTER;
				id     = pick_pending_id();
				exc    = 1'b0;
				cancel = 1'b0;
			end
			send_job(cmd, id, exc, cancel);
		end
	endtask

	task automatic test_open_source();
		write_job_count(ID_MAX);
		random_traffic(1100);
	endtask

	task automatic test_limited_source();
		write_job_count(exp_next_id[ID_W-1:0] - 1'b1 + ID_W'($urandom_range(5, 40)));
		random_traffic(300);
	endtask

	// Only one terminal mode is reachable per reset: the seed picks which
	task automatic test_terminal_mode();
		logic to_exception;
		logic [ID_W-1:0] id;
		int roll;
		write_job_count(ID_MAX);
		// Complete the base whenever the window is full so that the pending set grows
		while (exp_pending_total < 12) begin
			if (exp_next_id - exp_base >= JCWT_WINDOW)
				send_job(CMD_REGISTER, exp_base[ID_W-1:0], 1'b0, 1'b0);
			else
				send_job(CMD_ACQUIRE, ID_W'($urandom_range(1, ID_MAX)), 1'b0, 1'b0);
		end
		to_exception = 1'($urandom_range(0, 1));
		id = pick_pending_id();
		if (to_exception)
			send_job(CMD_REGISTER, id, 1'b1, 1'($urandom_range(0, 1)));
		else
			send_job(CMD_REGISTER, id, 1'b0, 1'b1);
		while (exp_pending_total > 0) begin
			roll = $urandom_range(0, 99);
			if (roll < 20)
				send_job(CMD_ACQUIRE, ID_W'($urandom_range(1, ID_MAX)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			else if (roll < 30)
				send_job(CMD_REGISTER, pick_stray_id(),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			else
				send_job(CMD_REGISTER, pick_pending_id(),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
		write_job_count(24'd1);
		send_job(CMD_ACQUIRE, 24'd1, 1'b0, 1'b0);
		send_job(CMD_REGISTER, pick_stray_id(), 1'b1, 1'b1);
	endtask

	initial begin
		arst_n                     = 1'b0;
		job_in_ch.valid            = 1'b0;
		job_in_ch.command          = CMD_ACQUIRE;
		job_in_ch.job_id           = '0;
		job_in_ch.exceptional      = 1'b0;
		job_in_ch.cancel_requested = 1'b0;
		job_out_ch.ready           = 1'b0;
		cfg_ch.valid               = 1'b0;
		cfg_ch.data                = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_source();
		test_small_source();
		test_open_source();
		test_limited_source();
		test_terminal_mode();
		wait_idle();

		$display("Covered %0d requests, %0d results: %0d ok, %0d exhausted, %0d full, %0d bad id.",
			items_sent, results_seen, status_tally[ST_OK], status_tally[ST_EXHAUSTED],
			status_tally[ST_FULL], status_tally[ST_BAD_ID]);
		$display("Ended in run mode %0d with %0d exceptions recorded, first at id %0d.",
			exp_mode, exp_exc_count, exp_first_bad);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Receiver: runs of ready broken by short stalls, now and then a long free run
	always @(negedge clk) begin
		if (ready_stall > 0) begin
			job_out_ch.ready <= 1'b0;
			ready_stall--;
		end else begin
			job_out_ch.ready <= 1'b1;
			if (ready_run > 0) begin
				ready_run--;
			end else begin
				ready_run   = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
					: $urandom_range(1, 12);
				ready_stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end
		end
	end

	function automatic void check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		job_result_t want;
		if (arst_n && job_out_ch.valid && job_out_ch.ready) begin
			results_seen++;
			status_tally[job_out_ch.status]++;
			if (outcome_queue.size() == 0) begin
				$error("result transfer with no request outstanding");
				error_count++;
			end else begin
				want = outcome_queue.pop_front();
				check_field("status", want.status, job_out_ch.status);
				check_field("granted_id", want.granted_id, job_out_ch.granted_id);
				check_field("exhausted", want.exhausted, job_out_ch.exhausted);
				check_field("lowest_unfinished", want.lowest_unfinished,
					job_out_ch.lowest_unfinished);
				check_field("pending_count", want.pending_count, job_out_ch.pending_count);
				check_field("exception_count", want.exception_count,
					job_out_ch.exception_count);
				check_field("first_exception_id", want.first_exception_id,
					job_out_ch.first_exception_id);
				check_field("run_mode", want.run_mode, job_out_ch.run_mode);
			end
		end
	end

	// Watchdog: give up after a long stretch with no transfer on any channel
	always @(posedge clk) begin
		if ((job_in_ch.valid && job_in_ch.ready) || (job_out_ch.valid && job_out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timed out with %0d results outstanding", outcome_queue.size());
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
